// File: rtl/mctt_pkg.sv
// mctt_pkg: shared constants and types for the midi clock tempo tracker
// no dependencies; used by every module under rtl
`default_nettype none

package mctt_pkg;

  // interval window depth (1 to 64) and derived widths
  localparam int WINDOW_DEPTH = 8;
  localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  localparam int TS_W   = 32;  // timestamp width
  localparam int IVL_W  = 16;  // saturated interval width, also bpm width
  localparam int SUM_W  = IVL_W + $clog2(WINDOW_DEPTH);

  // bpm = floor(BPM_NUM / sum)
  localparam int BPM_NUM = 625 * WINDOW_DEPTH;
  localparam int NUM_W   = $clog2(BPM_NUM + 1);
  localparam int QCNT_W  = $clog2(NUM_W);

  // digit-serial timestamp subtract
  localparam int DIGIT_W = 4;
  localparam int DIGITS  = TS_W / DIGIT_W;
  localparam int DCNT_W  = $clog2(DIGITS);

  // opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // phase values
  localparam logic [1:0] PHASE_ZERO = 2'd0;
  localparam logic [1:0] PHASE_ONE  = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_SUM,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic dlt_start;
    logic sum_load;
    logic div_start;
    logic out_load;
  } ctrl_t;

endpackage

`default_nettype wire

// File: rtl/mctt_delta.sv
// mctt_delta: digit-serial 32-bit timestamp subtract with 16-bit saturation
// depends on mctt_pkg
`default_nettype none

module mctt_delta (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [mctt_pkg::TS_W-1:0]   now,
  input  wire logic [mctt_pkg::TS_W-1:0]   last,
  output logic                             done,
  output logic [mctt_pkg::IVL_W-1:0]       delta
);

  logic [mctt_pkg::TS_W-1:0]    a_sh_r;
  logic [mctt_pkg::TS_W-1:0]    b_sh_r;
  logic [mctt_pkg::TS_W-1:0]    diff_r;
  logic                         carry_r;
  logic [mctt_pkg::DCNT_W-1:0]  cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [mctt_pkg::DIGIT_W:0]   dsum;

  // a + ~b + carry, one digit per cycle
  assign dsum = {1'b0, a_sh_r[mctt_pkg::DIGIT_W-1:0]}
              + {1'b0, ~b_sh_r[mctt_pkg::DIGIT_W-1:0]}
              + {{mctt_pkg::DIGIT_W{1'b0}}, carry_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        carry_r <= 1'b1;
        a_sh_r <= now;
        b_sh_r <= last;
      end else if (busy_r) begin
        a_sh_r  <= a_sh_r >> mctt_pkg::DIGIT_W;
        b_sh_r  <= b_sh_r >> mctt_pkg::DIGIT_W;
        diff_r  <= {dsum[mctt_pkg::DIGIT_W-1:0], diff_r[mctt_pkg::TS_W-1:mctt_pkg::DIGIT_W]};
        carry_r <= dsum[mctt_pkg::DIGIT_W];
        cnt_r   <= cnt_r + 1'b1;
        if (cnt_r == mctt_pkg::DCNT_W'(mctt_pkg::DIGITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign delta = (|diff_r[mctt_pkg::TS_W-1:mctt_pkg::IVL_W]) ? '1
               : diff_r[mctt_pkg::IVL_W-1:0];

endmodule

`default_nettype wire

// File: rtl/mctt_div.sv
// mctt_div: restoring divider, one quotient bit per cycle, constant dividend
// depends on mctt_pkg
`default_nettype none

module mctt_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [mctt_pkg::SUM_W-1:0]   divisor,
  output logic                              done,
  output logic [mctt_pkg::NUM_W-1:0]        quotient
);

  logic [mctt_pkg::SUM_W-1:0]   rem_r;
  logic [mctt_pkg::NUM_W-1:0]   num_r;
  logic [mctt_pkg::NUM_W-1:0]   quo_r;
  logic [mctt_pkg::SUM_W-1:0]   div_r;
  logic [mctt_pkg::QCNT_W-1:0]  cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [mctt_pkg::SUM_W:0]     trial;
  logic                         ge;

  // remainder stays below the divisor, so it fits in SUM_W bits
  assign trial = {rem_r, num_r[mctt_pkg::NUM_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= '0;
        num_r  <= mctt_pkg::NUM_W'(mctt_pkg::BPM_NUM);
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? mctt_pkg::SUM_W'(trial - {1'b0, div_r}) : trial[mctt_pkg::SUM_W-1:0];
        quo_r <= {quo_r[mctt_pkg::NUM_W-2:0], ge};
        num_r <= {num_r[mctt_pkg::NUM_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == mctt_pkg::QCNT_W'(mctt_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: rtl/midi_clock_tempo_tracker_top.sv
// midi clock tempo tracker: a tick runs the digit-serial timestamp subtract, the window update,
// the serial divider (skipped on a zero window sum) and then loads the output register; other
// opcodes go straight to the output register. One transaction at a time: in_ready is high only
// in idle, after the last result has loaded, and that load waits on out_ready
// synchronous active-low reset clears the window, sum, pointer, phase and last time
// depends on mctt_pkg, mctt_delta, mctt_div
`default_nettype none

module midi_clock_tempo_tracker_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_opcode,
  input  wire logic [mctt_pkg::TS_W-1:0]  in_timestamp,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [mctt_pkg::IVL_W-1:0]      out_bpm,
  output logic                            out_bpm_update,
  output logic                            out_step_reset,
  output logic                            out_run_set,
  output logic                            out_run_value,
  output logic                            out_step_count_load,
  output logic [1:0]                      out_clock_phase
);

  mctt_pkg::state_t state_r, state_nxt;
  mctt_pkg::ctrl_t  ctrl;

  // tracker state
  logic [mctt_pkg::IVL_W-1:0]  window_r [mctt_pkg::WINDOW_DEPTH];
  logic [mctt_pkg::PTR_W-1:0]  wptr_r;
  logic [mctt_pkg::TS_W-1:0]   last_time_r;
  logic [1:0]                  phase_r;
  logic [mctt_pkg::SUM_W-1:0]  sum_r;

  // staged result of the transaction in flight
  logic [mctt_pkg::IVL_W-1:0]  res_bpm_r;
  logic                        res_upd_r;
  logic                        res_srst_r;
  logic                        res_rset_r;
  logic                        res_rval_r;
  logic                        res_load_r;

  // output register
  logic                        out_valid_r;
  logic [mctt_pkg::IVL_W-1:0]  out_bpm_r;
  logic                        out_upd_r;
  logic                        out_srst_r;
  logic                        out_rset_r;
  logic                        out_rval_r;
  logic                        out_load_r;
  logic [1:0]                  out_phase_r;

  logic                        in_fire;
  logic                        is_tick;
  logic                        out_free;
  logic [2:0]                  phase_inc;
  logic                        dlt_done;
  logic [mctt_pkg::IVL_W-1:0]  dlt_value;
  logic                        div_done;
  logic [mctt_pkg::NUM_W-1:0]  div_quo;
  logic [mctt_pkg::SUM_W-1:0]  sum_upd;

  assign in_fire   = in_valid && ctrl.in_ready;
  assign is_tick   = (in_opcode == mctt_pkg::OP_TICK);
  assign out_free  = !out_valid_r || out_ready;
  assign phase_inc = {1'b0, phase_r} + 3'd1;

  // running sum: drop the oldest interval, add the new one
  assign sum_upd = sum_r - mctt_pkg::SUM_W'(window_r[wptr_r])
                 + mctt_pkg::SUM_W'(dlt_value);

  // interval since the last tick or start, one digit per cycle
  mctt_delta u_delta (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctrl.dlt_start),
    .now   (in_timestamp),
    .last  (last_time_r),
    .done  (dlt_done),
    .delta (dlt_value)
  );

  // tempo = BPM_NUM / window sum, one bit per cycle
  mctt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .divisor  (sum_upd),
    .done     (div_done),
    .quotient (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mctt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = is_tick ? mctt_pkg::S_DELTA : mctt_pkg::S_OUT;
        end
      end
      mctt_pkg::S_DELTA: begin
        if (dlt_done) begin
          state_nxt = mctt_pkg::S_SUM;
        end
      end
      mctt_pkg::S_SUM: begin
        // an empty window skips the divider
        state_nxt = (sum_upd == '0) ? mctt_pkg::S_OUT : mctt_pkg::S_DIV;
      end
      mctt_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = mctt_pkg::S_OUT;
        end
      end
      mctt_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = mctt_pkg::S_IDLE;
        end
      end
      default: state_nxt = mctt_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      mctt_pkg::S_IDLE: begin
        ctrl.in_ready  = 1'b1;
        ctrl.dlt_start = in_valid && is_tick;
      end
      mctt_pkg::S_DELTA: ;
      mctt_pkg::S_SUM: begin
        ctrl.sum_load  = 1'b1;
        ctrl.div_start = (sum_upd != '0);
      end
      mctt_pkg::S_DIV: ;
      mctt_pkg::S_OUT: begin
        ctrl.out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mctt_pkg::S_IDLE;
      wptr_r      <= '0;
      last_time_r <= '0;
      phase_r     <= mctt_pkg::PHASE_ZERO;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mctt_pkg::WINDOW_DEPTH; i++) begin
        window_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      // decode the transaction at accept
      if (in_fire) begin
        res_bpm_r  <= '0;
        res_upd_r  <= 1'b0;
        res_srst_r <= 1'b0;
        res_rset_r <= 1'b0;
        res_rval_r <= 1'b0;
        res_load_r <= 1'b0;
        unique case (in_opcode)
          mctt_pkg::OP_TICK: begin
            res_upd_r   <= 1'b1;
            last_time_r <= in_timestamp;
            // phase runs 1, 2, 3, 1, ... with a step reset on each 1
            if (phase_inc == 3'd1 || phase_inc >= 3'd4) begin
              phase_r    <= mctt_pkg::PHASE_ONE;
              res_srst_r <= 1'b1;
            end else begin
              phase_r <= phase_inc[1:0];
            end
          end
          mctt_pkg::OP_START: begin
            phase_r     <= mctt_pkg::PHASE_ZERO;
            res_rset_r  <= 1'b1;
            res_rval_r  <= 1'b1;
            res_load_r  <= 1'b1;
            last_time_r <= in_timestamp;
          end
          mctt_pkg::OP_STOP: begin
            res_rset_r <= 1'b1;
          end
          default: ;  // unused opcode leaves state alone
        endcase
      end

      // window write and sum update
      if (ctrl.sum_load) begin
        window_r[wptr_r] <= dlt_value;
        sum_r            <= sum_upd;
        wptr_r           <= (wptr_r == mctt_pkg::PTR_W'(mctt_pkg::WINDOW_DEPTH - 1)) ? '0
                          : wptr_r + 1'b1;
        if (sum_upd == '0) begin
          res_bpm_r <= '1;  // empty window saturates
        end
      end

      if (div_done) begin
        res_bpm_r <= mctt_pkg::IVL_W'(div_quo);
      end

      // output register, loads once the previous transaction has left
      if (ctrl.out_load) begin
        out_valid_r <= 1'b1;
        out_bpm_r   <= res_bpm_r;
        out_upd_r   <= res_upd_r;
        out_srst_r  <= res_srst_r;
        out_rset_r  <= res_rset_r;
        out_rval_r  <= res_rval_r;
        out_load_r  <= res_load_r;
        out_phase_r <= phase_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready            = ctrl.in_ready;
  assign out_valid           = out_valid_r;
  assign out_bpm             = out_bpm_r;
  assign out_bpm_update      = out_upd_r;
  assign out_step_reset      = out_srst_r;
  assign out_run_set         = out_rset_r;
  assign out_run_value       = out_rval_r;
  assign out_step_count_load = out_load_r;
  assign out_clock_phase     = out_phase_r;

`ifndef SYNTHESIS
  // the divider only ever runs on a nonzero window sum
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mctt_pkg::S_DIV) |-> (sum_r != '0))
    else $error("divider running on empty window sum");

  // a tempo transaction never carries a run command
  a_upd_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bpm_update) |-> !out_run_set && !out_step_count_load)
    else $error("tempo update mixed with run command");

  // step reset always lands on phase one
  a_srst_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_step_reset) |-> (out_clock_phase == mctt_pkg::PHASE_ONE))
    else $error("step reset on wrong phase");

  // a start clears the phase and commands run
  a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_step_count_load)
      |-> (out_clock_phase == mctt_pkg::PHASE_ZERO) && out_run_value && out_run_set)
    else $error("start transaction with bad phase or run command");
`endif

endmodule

`default_nettype wire

// File: tb/midi_clock_tempo_tracker_top_tb.sv
// self-checking testbench for midi_clock_tempo_tracker_top: directed and random midi clock,
// start and stop events, with every transaction checked against a tempo predictor
// depends on mctt_pkg and the rtl of midi_clock_tempo_tracker_top
module midi_clock_tempo_tracker_top_tb;

  // opcode the block must ignore (no state change, phase only)
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned EVENT_TARGET = 850;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned MAX_REPORTS  = 40;

  localparam int unsigned IVL_SAT     = 65535;   // longest interval in ms
  localparam int unsigned BPM_SAT     = 65535;   // tempo shown for an empty window
  localparam int unsigned TEMPO_SCALE = 625;     // 60000 / (24 ppqn * 4)

  typedef struct packed {
    logic [1:0]                opcode;
    logic [mctt_pkg::TS_W-1:0] stamp;
  } midi_event_t;

  typedef struct packed {
    logic [mctt_pkg::IVL_W-1:0] bpm;
    logic                       bpm_update;
    logic                       step_reset;
    logic                       run_set;
    logic                       run_value;
    logic                       step_count_load;
    logic [1:0]                 clock_phase;
  } tempo_result_t;

  // block inputs, known from time zero
  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      in_valid     = 1'b0;
  logic [1:0]                in_opcode    = mctt_pkg::OP_TICK;
  logic [mctt_pkg::TS_W-1:0] in_timestamp = '0;
  logic                      out_ready    = 1'b0;

  logic                       in_ready;
  logic                       out_valid;
  logic [mctt_pkg::IVL_W-1:0] out_bpm;
  logic                       out_bpm_update;
  logic                       out_step_reset;
  logic                       out_run_set;
  logic                       out_run_value;
  logic                       out_step_count_load;
  logic [1:0]                 out_clock_phase;

  midi_clock_tempo_tracker_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_timestamp        (in_timestamp),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_bpm             (out_bpm),
    .out_bpm_update      (out_bpm_update),
    .out_step_reset      (out_step_reset),
    .out_run_set         (out_run_set),
    .out_run_value       (out_run_value),
    .out_step_count_load (out_step_count_load),
    .out_clock_phase     (out_clock_phase)
  );

  always #10 clk = ~clk;

  // stimulus and expectation stores
  midi_event_t   midi_events[$];
  tempo_result_t pending_tempo_results[$];

  // tracker copy: interval window, pointer, last stamp, phase, running sum
  logic [mctt_pkg::IVL_W-1:0] ivl_window [mctt_pkg::WINDOW_DEPTH];
  int unsigned                win_ptr;
  logic [mctt_pkg::TS_W-1:0]  last_stamp;
  logic [1:0]                 phase;
  int unsigned                win_sum;

  // run statistics
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned results_checked;
  int unsigned tick_count, start_count, stop_count, unused_count;
  int unsigned long_ivl_count, zero_sum_count, step_reset_count;

  // handshake pacing
  int unsigned send_gap;
  int unsigned recv_stall;
  logic        steady = 1'b0;   // stretches with no idling on either side

  function automatic int unsigned idle_len(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // works out the result of one accepted transaction and queues it
  task automatic track_tempo_event(input midi_event_t ev);
    logic [mctt_pkg::TS_W-1:0] delta;
    int unsigned               ivl;
    int unsigned               quot;
    tempo_result_t             res;
    res = '0;
    case (ev.opcode)
      mctt_pkg::OP_TICK: begin
        tick_count++;
        // modular interval, then saturate to 16 bits
        delta = ev.stamp - last_stamp;
        ivl   = (delta > IVL_SAT) ? IVL_SAT : int'(delta);
        if (ivl == IVL_SAT) long_ivl_count++;
        last_stamp = ev.stamp;
        win_sum = win_sum - ivl_window[win_ptr] + ivl;
        ivl_window[win_ptr] = mctt_pkg::IVL_W'(ivl);
        win_ptr = (win_ptr + 1 >= mctt_pkg::WINDOW_DEPTH) ? 0 : win_ptr + 1;
        if (win_sum == 0) begin
          zero_sum_count++;
          res.bpm = mctt_pkg::IVL_W'(BPM_SAT);
        end else begin
          quot = (TEMPO_SCALE * mctt_pkg::WINDOW_DEPTH) / win_sum;
          res.bpm = mctt_pkg::IVL_W'((quot > BPM_SAT) ? BPM_SAT : quot);
        end
        res.bpm_update = 1'b1;
        // phase runs 1, 2, 3, 1, ... with a step reset each time it lands on 1
        if (phase == mctt_pkg::PHASE_ZERO || phase == 2'd3) begin
          phase = mctt_pkg::PHASE_ONE;
          res.step_reset = 1'b1;
          step_reset_count++;
        end else begin
          phase = phase + 2'd1;
        end
      end
      mctt_pkg::OP_START: begin
        start_count++;
        phase               = mctt_pkg::PHASE_ZERO;
        last_stamp          = ev.stamp;
        res.run_set         = 1'b1;
        res.run_value       = 1'b1;
        res.step_count_load = 1'b1;
      end
      mctt_pkg::OP_STOP: begin
        stop_count++;
        res.run_set = 1'b1;
      end
      default: begin
        unused_count++;
      end
    endcase
    res.clock_phase = phase;
    pending_tempo_results.push_back(res);
  endtask

  // driver: one transaction in flight, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) track_tempo_event(midi_event_t'{in_opcode, in_timestamp});
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (midi_events.size() != 0) begin
          in_opcode    <= midi_events[0].opcode;
          in_timestamp <= midi_events[0].stamp;
          midi_events.pop_front();
          in_valid     <= 1'b1;
          send_gap     <= idle_len(steady);
          if ($urandom_range(0, 49) == 0) steady <= !steady;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, compare each result with the oldest expectation
  always @(posedge clk) begin
    tempo_result_t exp_res;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_tempo_results.size() == 0) begin
          report_error("result transaction with nothing expected");
        end else begin
          exp_res = pending_tempo_results.pop_front();
          results_checked++;
          if (out_bpm !== exp_res.bpm)
            report_error($sformatf("bpm got %0d exp %0d", out_bpm, exp_res.bpm));
          if (out_bpm_update !== exp_res.bpm_update)
            report_error($sformatf("bpm_update got %b exp %b",
                                   out_bpm_update, exp_res.bpm_update));
          if (out_step_reset !== exp_res.step_reset)
            report_error($sformatf("step_reset got %b exp %b",
                                   out_step_reset, exp_res.step_reset));
          if (out_run_set !== exp_res.run_set)
            report_error($sformatf("run_set got %b exp %b", out_run_set, exp_res.run_set));
          if (out_run_value !== exp_res.run_value)
            report_error($sformatf("run_value got %b exp %b",
                                   out_run_value, exp_res.run_value));
          if (out_step_count_load !== exp_res.step_count_load)
            report_error($sformatf("step_count_load got %b exp %b",
                                   out_step_count_load, exp_res.step_count_load));
          if (out_clock_phase !== exp_res.clock_phase)
            report_error($sformatf("clock_phase got %0d exp %0d",
                                   out_clock_phase, exp_res.clock_phase));
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_ready  <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        recv_stall <= idle_len(1'b0);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_tempo_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  int unsigned queued;

  task automatic add_event(input logic [1:0] op, input logic [mctt_pkg::TS_W-1:0] stamp);
    midi_events.push_back(midi_event_t'{op, stamp});
    queued++;
  endtask

  initial begin
    logic [mctt_pkg::TS_W-1:0] ts;
    int                        base_ivl;
    int                        ivl;
    int unsigned               n_ticks;
    int unsigned               r;

    err_count = 0;
    cycle_count = 0;
    results_checked = 0;
    queued = 0;
    {tick_count, start_count, stop_count, unused_count} = '0;
    {long_ivl_count, zero_sum_count, step_reset_count} = '0;
    foreach (ivl_window[i]) ivl_window[i] = '0;
    win_ptr = 0;
    last_stamp = '0;
    phase = mctt_pkg::PHASE_ZERO;
    win_sum = 0;

    // directed: empty window sums, saturation, wrap, phase cycling
    add_event(mctt_pkg::OP_TICK, 32'd0);                   // zero interval, zero sum
    add_event(mctt_pkg::OP_TICK, 32'd0);
    add_event(mctt_pkg::OP_TICK, 32'd5);
    add_event(mctt_pkg::OP_TICK, 32'd70005);               // long interval saturates
    add_event(OP_UNUSED, 32'hDEAD_BEEF);                   // ignored opcode
    add_event(mctt_pkg::OP_START, 32'hFFFF_FFF0);
    add_event(mctt_pkg::OP_TICK, 32'h0000_0005);           // interval across timestamp wrap
    add_event(mctt_pkg::OP_TICK, 32'h0000_0005);
    add_event(mctt_pkg::OP_STOP, 32'h1234_5678);           // stop leaves stamp and phase alone
    add_event(mctt_pkg::OP_TICK, 32'h0000_0010);
    ts = 32'h0000_0010;
    for (int i = 0; i < mctt_pkg::WINDOW_DEPTH; i++) begin // window full of maximum intervals
      ts = ts + IVL_SAT;
      add_event(mctt_pkg::OP_TICK, ts);
    end
    add_event(mctt_pkg::OP_TICK, ts - 1);                  // backwards stamp, huge interval
    add_event(mctt_pkg::OP_TICK, 32'hFFFF_FFFF);
    add_event(mctt_pkg::OP_START, 32'hFFFF_FFFF);
    add_event(mctt_pkg::OP_TICK, 32'h0000_0000);
    add_event(OP_UNUSED, 32'h0000_0000);

    // random: mostly start, a run of steady ticks, stop; some noise and stray ticks
    while (queued < EVENT_TARGET) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        ts = $urandom();
        add_event(mctt_pkg::OP_START, ts);
        base_ivl = $urandom_range(1, 60);
        n_ticks  = $urandom_range(3, 40);
        for (int i = 0; i < n_ticks; i++) begin
          r = $urandom_range(0, 99);
          if (r < 80) begin
            ivl = base_ivl + int'($urandom_range(0, 6)) - 3;
            if (ivl < 0) ivl = 0;
          end else if (r < 88) begin
            ivl = 0;
          end else if (r < 94) begin
            ivl = $urandom_range(60000, 140000);
          end else if (r < 97) begin
            ivl = $urandom();
          end else begin
            // mid-run noise: stop or ignored opcode, then carry on ticking
            add_event(($urandom_range(0, 1) == 0) ? mctt_pkg::OP_STOP : OP_UNUSED,
                      $urandom());
            ivl = base_ivl;
          end
          ts = ts + ivl;
          add_event(mctt_pkg::OP_TICK, ts);
        end
        if ($urandom_range(0, 3) != 0)
          add_event(mctt_pkg::OP_STOP, ts + $urandom_range(0, 100));
      end else if (r == 8) begin
        for (int i = 0; i < 4; i++) add_event(2'($urandom_range(0, 3)), $urandom());
      end else begin
        // ticks with no preceding start
        n_ticks = $urandom_range(1, 6);
        for (int i = 0; i < n_ticks; i++) begin
          ts = ts + $urandom_range(0, 200);
          add_event(mctt_pkg::OP_TICK, ts);
        end
      end
    end

    // reset once, then let the driver run
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (midi_events.size() != 0 || in_valid || pending_tempo_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results: %0d ticks, %0d starts, %0d stops, %0d ignored opcodes",
             results_checked, tick_count, start_count, stop_count, unused_count);
    $display("saturated intervals %0d, empty window sums %0d, step resets %0d, errors %0d",
             long_ivl_count, zero_sum_count, step_reset_count, err_count);
    if (err_count == 0 && pending_tempo_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mctt_pkg.sv
rtl/mctt_delta.sv
rtl/mctt_div.sv
rtl/midi_clock_tempo_tracker_top.sv
tb/midi_clock_tempo_tracker_top_tb.sv
